// ----- src/stq_pkg.sv -----
// Shared types, widths and codes for the sorted timer queue.
// Used by stq_cell, stq_row and sorted_timer_queue; depends on nothing.
package stq_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int NUM_CLASSES = 2;
  localparam int WAKE_CLASS  = (NUM_CLASSES > 1) ? 1 : 0;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  localparam int TIME_W     = 48;
  localparam int ID_W       = 4;
  localparam int OP_W       = 3;
  localparam int KIND_W     = 3;
  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 56;

  localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

  // Operation codes on in_tuser.
  localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd0;
  localparam logic [OP_W-1:0] OP_CANCEL   = 3'd1;
  localparam logic [OP_W-1:0] OP_SERVICE  = 3'd2;
  localparam logic [OP_W-1:0] OP_ADJUST   = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

  // Result kinds on out_tuser.
  localparam logic [KIND_W-1:0] KIND_FIRED   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WAIT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WAKE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_WAKE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DONE    = 3'd5;

  // Row commands broadcast to every cell of a class.
  localparam logic [CMD_W-1:0] CMD_HOLD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADJUST = 3'd4;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   slot;
  } stq_entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] key;
    logic [TIME_W-1:0] step;
  } stq_ctl_t;

endpackage

// ----- src/sorted_timer_queue.sv -----
// Sorted timer queue: schedule, cancel, service, adjust and query over sorted timer rows.
// Cancel, adjust, query and unknown codes give their result from the EXEC state, schedule
// from the INSERT state after EXEC (remove, then insert); service gives one result per cycle
// while out_tready allows; all result loads wait on it. A new input is taken only in IDLE.
// Reset clears the valid bits of every cell and the handshake state; no clearing pass.
// Depends on stq_pkg and stq_row.
module sorted_timer_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // timer_id [3:0], wake_class [4], delay [52:5], now_time [100:53], step [148:101]
  input  logic [stq_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [stq_pkg::OP_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // fired_id [3:0], time_value [51:4]
  output logic [stq_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic [stq_pkg::KIND_W-1:0]     out_tuser,
  output logic                           out_tlast
);
  import stq_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_EXEC    = 2'd1;
  localparam logic [1:0] ST_INSERT  = 2'd2;
  localparam logic [1:0] ST_SERVICE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [CLS_W-1:0]  cls_r;
  logic [TIME_W-1:0] key_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] step_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic [TIME_W-1:0] out_time_r;
  logic              out_last_r;

  logic              in_xfer;
  logic              out_free;
  logic [TIME_W:0]   in_sum;
  logic [TIME_W-1:0] in_key;
  logic [CLS_W-1:0]  in_cls;
  logic              id_ok;

  logic              load_out;
  logic [KIND_W-1:0] emit_kind;
  logic [ID_W-1:0]   emit_id;
  logic [TIME_W-1:0] emit_time;
  logic              emit_last;

  logic [CMD_W-1:0]  row_cmd  [NUM_CLASSES];
  stq_ctl_t          row_ctl  [NUM_CLASSES];
  stq_entry_t        row_head [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] row_full;

  logic              svc_hit;
  logic [TIME_W-1:0] svc_best;
  logic [CLS_W-1:0]  svc_win;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    in_sum = {1'b0, in_tdata[100:53]} + {1'b0, in_tdata[52:5]};
    in_key = in_sum[TIME_W] ? TMAX : in_sum[TIME_W-1:0];
    in_cls = (32'(in_tdata[4]) >= NUM_CLASSES) ? CLS_W'(NUM_CLASSES - 1)
                                               : CLS_W'(in_tdata[4]);
  end

  assign id_ok = (32'(id_r) < NUM_TIMERS);

  // Earliest head across classes; on equal expiries the later class wins.
  always_comb begin
    svc_hit  = 1'b0;
    svc_best = '0;
    svc_win  = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (row_head[c].valid && (!svc_hit || row_head[c].expiry <= svc_best)) begin
        svc_hit  = 1'b1;
        svc_best = row_head[c].expiry;
        svc_win  = CLS_W'(c);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    emit_kind = KIND_DONE;
    emit_id   = '0;
    emit_time = '0;
    emit_last = 1'b1;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      row_cmd[c] = CMD_HOLD;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = (in_tuser == OP_SERVICE) ? ST_SERVICE : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_SCHEDULE && id_ok) begin
          for (int c = 0; c < NUM_CLASSES; c++) begin
            row_cmd[c] = CMD_REMOVE;
          end
          state_nxt = ST_INSERT;
        end else if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          case (op_r)
            OP_CANCEL: begin
              if (id_ok) begin
                for (int c = 0; c < NUM_CLASSES; c++) begin
                  row_cmd[c] = CMD_REMOVE;
                end
              end
            end
            OP_ADJUST: begin
              for (int c = 0; c < NUM_CLASSES; c++) begin
                row_cmd[c] = CMD_ADJUST;
              end
            end
            OP_QUERY: begin
              if (row_head[WAKE_CLASS].valid) begin
                emit_kind = KIND_WAKE;
                emit_time = row_head[WAKE_CLASS].expiry;
              end else begin
                emit_kind = KIND_NO_WAKE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          if (!row_full[cls_r]) begin
            row_cmd[cls_r] = CMD_INSERT;
          end
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SERVICE: begin
        if (out_free) begin
          load_out = 1'b1;
          if (!svc_hit) begin
            emit_kind = KIND_NONE;
            state_nxt = ST_IDLE;
          end else if (svc_best > now_r) begin
            emit_kind = KIND_WAIT;
            emit_time = svc_best - now_r;
            state_nxt = ST_IDLE;
          end else begin
            emit_kind        = KIND_FIRED;
            emit_id          = row_head[svc_win].slot;
            emit_last        = 1'b0;
            row_cmd[svc_win] = CMD_POP;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      row_ctl[c] = '{cmd: row_cmd[c], id: id_r, key: key_r, step: step_r};
    end
  end

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_row
    stq_row u_row (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (row_ctl[c]),
      .head_o (row_head[c]),
      .full_o (row_full[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_tuser;
      id_r   <= in_tdata[3:0];
      cls_r  <= in_cls;
      key_r  <= in_key;
      now_r  <= in_tdata[100:53];
      step_r <= in_tdata[148:101];
    end
    if (load_out) begin
      out_kind_r <= emit_kind;
      out_id_r   <= emit_id;
      out_time_r <= emit_time;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - TIME_W - ID_W){1'b0}}, out_time_r, out_id_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // A service run ends only by loading its closing result.
  a_svc_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SERVICE ##1 state_r == ST_IDLE) |-> (out_valid_r && out_last_r))
    else $error("service finished without a closing result");

  // A fired timer is never the closing result of a service run.
  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_FIRED) |-> !out_last_r)
    else $error("fired result marked as last");

  // An accepted transfer always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("accepted input left the block idle");

endmodule

// ----- src/stq_cell.sv -----
// One cell of a sorted timer row: holds one timer and trades it with its neighbours.
// Depends on stq_pkg.
module stq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_pkg::stq_ctl_t  ctl,
  input  logic               mark_i,
  output logic               mark_o,
  input  stq_pkg::stq_entry_t left_i,
  input  stq_pkg::stq_entry_t right_i,
  output stq_pkg::stq_entry_t entry_o
);
  import stq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [TIME_W-1:0] expiry_r, expiry_nxt;
  logic [ID_W-1:0]   slot_r, slot_nxt;
  logic              hit;
  logic              le;
  logic [TIME_W+1:0] adj_sum;
  logic [TIME_W-1:0] adj_val;

  always_comb begin
    hit = valid_r && (slot_r == ctl.id);
    le  = valid_r && (expiry_r <= ctl.key);
    // For removal the mark says the hit lies at or left of this cell; for
    // insertion it says this cell stays where it is.
    mark_o = (ctl.cmd == CMD_REMOVE) ? (mark_i | hit) : le;

    adj_sum = {2'b00, expiry_r} + {{2{ctl.step[TIME_W-1]}}, ctl.step};
    if (adj_sum[TIME_W+1]) begin
      adj_val = '0;
    end else if (adj_sum[TIME_W]) begin
      adj_val = TMAX;
    end else begin
      adj_val = adj_sum[TIME_W-1:0];
    end

    valid_nxt  = valid_r;
    expiry_nxt = expiry_r;
    slot_nxt   = slot_r;
    case (ctl.cmd)
      CMD_REMOVE: begin
        if (mark_i | hit) begin
          valid_nxt  = right_i.valid;
          expiry_nxt = right_i.expiry;
          slot_nxt   = right_i.slot;
        end
      end
      CMD_INSERT: begin
        if (!le) begin
          if (mark_i) begin
            valid_nxt  = 1'b1;
            expiry_nxt = ctl.key;
            slot_nxt   = ctl.id;
          end else begin
            valid_nxt  = left_i.valid;
            expiry_nxt = left_i.expiry;
            slot_nxt   = left_i.slot;
          end
        end
      end
      CMD_POP: begin
        valid_nxt  = right_i.valid;
        expiry_nxt = right_i.expiry;
        slot_nxt   = right_i.slot;
      end
      CMD_ADJUST: begin
        if (valid_r) begin
          expiry_nxt = adj_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    expiry_r <= expiry_nxt;
    slot_r   <= slot_nxt;
  end

  assign entry_o = '{valid: valid_r, expiry: expiry_r, slot: slot_r};

endmodule

// ----- src/stq_row.sv -----
// One class of timers: a row of stq_cell kept packed and sorted by expiry.
// Depends on stq_pkg and stq_cell.
module stq_row (
  input  logic                clk,
  input  logic                rst_n,
  input  stq_pkg::stq_ctl_t   ctl,
  output stq_pkg::stq_entry_t head_o,
  output logic                full_o
);
  import stq_pkg::*;

  stq_entry_t                entry [NUM_TIMERS];
  logic       [NUM_TIMERS:0] mark;
  logic       [NUM_TIMERS-1:0] valid_vec;
  logic       [NUM_TIMERS-1:0] order_ok;

  // The first cell sees an open slot on its left for insertion, no hit for removal.
  assign mark[0] = (ctl.cmd == CMD_INSERT);

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    stq_entry_t left_e, right_e;
    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = entry[i-1];
    end
    if (i == NUM_TIMERS - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry[i+1];
    end

    stq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .mark_i  (mark[i]),
      .mark_o  (mark[i+1]),
      .left_i  (left_e),
      .right_i (right_e),
      .entry_o (entry[i])
    );

    assign valid_vec[i] = entry[i].valid;
    if (i == 0) begin : g_ord0
      assign order_ok[i] = 1'b1;
    end else begin : g_ordn
      assign order_ok[i] = !entry[i].valid || (entry[i-1].expiry <= entry[i].expiry);
    end
  end

  assign head_o = entry[0];
  assign full_o = entry[NUM_TIMERS-1].valid;

  // Armed timers sit packed at the front of the row.
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("row valid bits are not packed at the front");

  // Neighbouring armed timers are in expiry order.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    &order_ok)
    else $error("row is not sorted by expiry");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for sorted_timer_queue: directed corners, random timer traffic and a
// back-pressure burst, checked against an in-bench predictor of both sorted timer classes.
// Depends on stq_pkg and sorted_timer_queue.
module tb;
  import stq_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] time_value;
    logic              last;
  } timer_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;

  sorted_timer_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Predicted contents of the two timer classes, packed and sorted by expiry.
  logic [TIME_W-1:0] expiry_tab [NUM_CLASSES][NUM_TIMERS];
  logic [ID_W-1:0]   slot_tab   [NUM_CLASSES][NUM_TIMERS];
  bit                armed_tab  [NUM_CLASSES][NUM_TIMERS];

  timer_report_t     due_reports[$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  int                rx_hold_len = 0;
  bit                rx_jitter = 1'b0;
  bit                tx_jitter = 1'b0;
  logic [TIME_W-1:0] wall_us = 48'd1000;

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  function automatic int armed_count(int c);
    int n;
    n = 0;
    while (n < NUM_TIMERS && armed_tab[c][n]) n++;
    return n;
  endfunction

  function automatic void drop_entry(int c, int p);
    int q;
    q = p;
    while (q + 1 < NUM_TIMERS && armed_tab[c][q+1]) begin
      expiry_tab[c][q] = expiry_tab[c][q+1];
      slot_tab[c][q]   = slot_tab[c][q+1];
      q++;
    end
    armed_tab[c][q] = 1'b0;
  endfunction

  function automatic void unlink_timer(logic [ID_W-1:0] id);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int p = 0; p < NUM_TIMERS && armed_tab[c][p]; p++) begin
        if (slot_tab[c][p] == id) begin
          drop_entry(c, p);
          return;
        end
      end
    end
  endfunction

  // A newcomer goes after every entry with an equal expiry.
  function automatic void place_timer(int c, logic [ID_W-1:0] id, logic [TIME_W-1:0] t);
    int n;
    int pos;
    n = armed_count(c);
    pos = 0;
    if (n >= NUM_TIMERS) return;
    while (pos < n && expiry_tab[c][pos] <= t) pos++;
    for (int q = n; q > pos; q--) begin
      expiry_tab[c][q] = expiry_tab[c][q-1];
      slot_tab[c][q]   = slot_tab[c][q-1];
    end
    expiry_tab[c][pos] = t;
    slot_tab[c][pos]   = id;
    armed_tab[c][n]    = 1'b1;
    armed_tab[c][pos]  = 1'b1;
  endfunction

  function automatic void expect_report(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                        logic [TIME_W-1:0] tv, logic last);
    timer_report_t r;
    r.kind       = kind;
    r.fired_id   = id;
    r.time_value = tv;
    r.last       = last;
    due_reports.push_back(r);
  endfunction

  function automatic void predict_timer_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                           logic wc, logic [TIME_W-1:0] dly,
                                           logic [TIME_W-1:0] now, logic [TIME_W-1:0] stp);
    int cls;
    int hit;
    int fired;
    logic [TIME_W-1:0] lowest;
    logic [TIME_W-1:0] mag;
    logic [TIME_W-1:0] e;
    cls = 0;
    hit = -1;
    fired = 0;
    lowest = '0;
    case (op)
      OP_SCHEDULE, OP_CANCEL: begin
        if (int'(id) < NUM_TIMERS) begin
          unlink_timer(id);
          if (op == OP_SCHEDULE) begin
            cls = (int'(wc) >= NUM_CLASSES) ? NUM_CLASSES - 1 : int'(wc);
            place_timer(cls, id, (dly > TMAX - now) ? TMAX : now + dly);
          end
        end
        expect_report(KIND_DONE, '0, '0, 1'b1);
      end
      OP_SERVICE: begin
        while (1) begin
          hit = -1;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (armed_tab[c][0] && (hit < 0 || expiry_tab[c][0] <= lowest)) begin
              hit = c;
              lowest = expiry_tab[c][0];
            end
          end
          if (hit < 0 || fired >= NUM_TIMERS * NUM_CLASSES) begin
            expect_report(KIND_NONE, '0, '0, 1'b1);
            break;
          end
          if (lowest > now) begin
            expect_report(KIND_WAIT, '0, lowest - now, 1'b1);
            break;
          end
          expect_report(KIND_FIRED, slot_tab[hit][0], '0, 1'b0);
          drop_entry(hit, 0);
          fired++;
        end
      end
      OP_ADJUST: begin
        mag = stp[TIME_W-1] ? (~stp + 1'b1) : stp;
        for (int c = 0; c < NUM_CLASSES; c++) begin
          for (int p = 0; p < NUM_TIMERS && armed_tab[c][p]; p++) begin
            e = expiry_tab[c][p];
            if (stp[TIME_W-1]) e = (e < mag) ? '0 : e - mag;
            else e = (e > TMAX - mag) ? TMAX : e + mag;
            expiry_tab[c][p] = e;
          end
        end
        expect_report(KIND_DONE, '0, '0, 1'b1);
      end
      OP_QUERY: begin
        if (armed_tab[WAKE_CLASS][0])
          expect_report(KIND_WAKE, '0, expiry_tab[WAKE_CLASS][0], 1'b1);
        else
          expect_report(KIND_NO_WAKE, '0, '0, 1'b1);
      end
      default: expect_report(KIND_DONE, '0, '0, 1'b1);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offers one item and updates the predictor at the clock edge of its transfer.
  task automatic send_item(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic wc,
                           logic [TIME_W-1:0] dly, logic [TIME_W-1:0] now,
                           logic [TIME_W-1:0] stp);
    int gap;
    gap = (tx_jitter && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, stp, now, dly, wc, id};
    do @(posedge clk); while (!in_tready);
    predict_timer_op(op, id, wc, dly, now, stp);
  endtask

  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    rx_jitter = 1'b0;
    tx_jitter = 1'b0;
    send_item(OP_QUERY, 4'd0, 1'b0, '0, '0, '0);
    send_item(OP_SERVICE, 4'd0, 1'b0, '0, '0, '0);
    send_item(OP_SPARE_A, 4'd5, 1'b1, TMAX, TMAX, TMAX);
    send_item(OP_SPARE_B, 4'd0, 1'b0, '0, '0, '0);
    send_item(OP_SPARE_C, 4'd9, 1'b1, 48'd7, 48'd3, 48'd1);
    send_item(OP_SCHEDULE, 4'd0, 1'b0, '0, '0, '0);
    send_item(OP_SCHEDULE, 4'd7, 1'b1, '0, '0, '0);
    send_item(OP_SCHEDULE, 4'd3, 1'b0, 48'd5, '0, '0);
    send_item(OP_SCHEDULE, 4'd4, 1'b0, 48'd5, '0, '0);
    // Both ends at their maximum, so the expiry saturates.
    send_item(OP_SCHEDULE, 4'd15, 1'b1, TMAX, TMAX, '0);
    send_item(OP_QUERY, 4'd0, 1'b0, '0, '0, '0);
    // Rescheduling an armed timer moves it into the other class.
    send_item(OP_SCHEDULE, 4'd3, 1'b1, 48'd2, 48'd1, '0);
    send_item(OP_CANCEL, 4'd9, 1'b0, '0, '0, '0);
    send_item(OP_CANCEL, 4'd4, 1'b0, '0, '0, '0);
    send_item(OP_ADJUST, 4'd0, 1'b0, '0, '0, 48'd10);
    // The tie at ten goes to the wake class.
    send_item(OP_SERVICE, 4'd0, 1'b0, '0, 48'd12, '0);
    send_item(OP_ADJUST, 4'd0, 1'b0, '0, '0, 48'h7FFF_FFFF_FFFF);
    send_item(OP_ADJUST, 4'd0, 1'b0, '0, '0, 48'h8000_0000_0000);
    send_item(OP_ADJUST, 4'd0, 1'b0, '0, '0, 48'h8000_0000_0000);
    send_item(OP_QUERY, 4'd0, 1'b0, '0, '0, '0);
    send_item(OP_SERVICE, 4'd0, 1'b0, '0, TMAX, '0);
    send_item(OP_SERVICE, 4'd0, 1'b0, '0, '0, '0);
    wait_for_reports();
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] stp;
    logic signed [TIME_W-1:0] small_step;
    for (int i = 0; i < count; i++) begin
      if (i % 20 == 0) begin
        rx_jitter = ($urandom_range(0, 3) != 0);
        tx_jitter = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 24) == 0) wait_for_reports();
      pick = $urandom_range(0, 99);
      dly  = rand48();
      now  = rand48();
      stp  = rand48();
      if (pick < 40) begin
        op = OP_SCHEDULE;
        case ($urandom_range(0, 19))
          0:       dly = TMAX;
          1, 2:    dly = rand48();
          default: dly = TIME_W'($urandom_range(0, 150));
        endcase
        if ($urandom_range(0, 14) != 0) now = wall_us;
      end else if (pick < 60) begin
        op = OP_SERVICE;
        wall_us = wall_us + TIME_W'($urandom_range(0, 120));
        if ($urandom_range(0, 14) != 0) now = wall_us;
      end else if (pick < 72) begin
        op = OP_CANCEL;
      end else if (pick < 82) begin
        op = OP_ADJUST;
        if ($urandom_range(0, 5) != 0) begin
          small_step = TIME_W'(int'($urandom_range(0, 60)) - 30);
          stp = small_step;
        end
      end else if (pick < 94) begin
        op = OP_QUERY;
      end else begin
        op = 3'($urandom_range(int'(OP_SPARE_A), int'(OP_SPARE_C)));
      end
      send_item(op, 4'($urandom_range(0, NUM_TIMERS - 1)), 1'($urandom()), dly, now, stp);
    end
    wait_for_reports();
  endtask

  // Arms every timer, then services them all while the receiver holds off, so the block
  // backs up and stalls its input.
  task automatic test_backpressure_burst();
    rx_jitter = 1'b0;
    tx_jitter = 1'b0;
    for (int id = 0; id < NUM_TIMERS; id++)
      send_item(OP_SCHEDULE, 4'(id), 1'($urandom()), 48'($urandom_range(0, 6)), wall_us,
                rand48());
    rx_hold_len = LONG_HOLD;
    send_item(OP_SERVICE, 4'd0, 1'b0, rand48(), wall_us + 48'd100, rand48());
    for (int i = 0; i < 8; i++)
      send_item(($urandom_range(0, 1) == 0) ? OP_QUERY : OP_SCHEDULE,
                4'($urandom_range(0, NUM_TIMERS - 1)), 1'($urandom()),
                48'($urandom_range(0, 50)), wall_us, rand48());
    wall_us = wall_us + 48'd200;
    wait_for_reports();
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin : receiver
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (rx_jitter && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    timer_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_reports.size() == 0) begin
        report_mismatch("unexpected result kind", 64'(out_tuser), '0);
      end else begin
        want = due_reports.pop_front();
        if (out_tuser != want.kind) report_mismatch("kind", 64'(out_tuser), 64'(want.kind));
        if (out_tdata[ID_W-1:0] != want.fired_id)
          report_mismatch("fired_id", 64'(out_tdata[ID_W-1:0]), 64'(want.fired_id));
        if (out_tdata[ID_W +: TIME_W] != want.time_value)
          report_mismatch("time_value", 64'(out_tdata[ID_W +: TIME_W]), 64'(want.time_value));
        if (out_tlast != want.last) report_mismatch("last", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < NUM_CLASSES; c++)
      for (int p = 0; p < NUM_TIMERS; p++) armed_tab[c][p] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_random_traffic(120);
    test_backpressure_burst();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_reports.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/stq_pkg.sv
src/stq_cell.sv
src/stq_row.sv
src/sorted_timer_queue.sv
bench/tb.sv
